// ===== rtl/core/tdes_ede_ctr_mode_core_defines.svh =====
// Assertion helpers for the TDES CTR core
`ifndef TDES_EDE_CTR_MODE_CORE_DEFINES_SVH
`define TDES_EDE_CTR_MODE_CORE_DEFINES_SVH

`define TDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdc assertion failed");

`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdc assertion failed");

`endif

// ===== rtl/core/tdc_pkg.sv =====
package tdc_pkg;

    localparam int BLOCK_BYTES_DEF = 8;
    localparam int WORD_BITS       = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int ROUNDS          = 16;
    localparam int RND_W           = 4;
    localparam int PASSES          = 3;
    localparam int PASS_W          = 2;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CTR_BITS  = 3'd4;

    typedef struct packed {
        logic [63:0] data_block;
        logic [3:0]  valid_bytes;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_block;
        logic [63:0] next_counter;
    } out_item_t;

    // queued job: counter to encrypt, data, byte mask, counter after step
    typedef struct packed {
        logic [63:0] ctr;
        logic [63:0] data;
        logic [63:0] keep;
        logic [63:0] next_ctr;
    } job_t;

    typedef struct packed {
        logic queue_full;
        logic queue_empty;
    } q_status_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_RUN,
        ENG_DONE
    } eng_state_t;

    localparam logic [7:0] PERM_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam logic [7:0] PERM_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [7:0] PERM_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam logic [7:0] PERM_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam logic [7:0] PERM_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam logic [7:0] PERM_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};
    localparam logic [1:0] ROT_AMT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip_f(input logic [63:0] s);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = s[64-int'(PERM_IP[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp_f(input logic [63:0] s);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = s[64-int'(PERM_FP[i])];
        return r;
    endfunction

    function automatic logic [55:0] pc1_f(input logic [63:0] s);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = s[64-int'(PERM_PC1[i])];
        return r;
    endfunction

    function automatic logic [47:0] pc2_f(input logic [55:0] s);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = s[56-int'(PERM_PC2[i])];
        return r;
    endfunction

    function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [1:0] s);
        logic [27:0] r;
        r = (s == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
        return r;
    endfunction

    function automatic logic [27:0] rotr28(input logic [27:0] v, input logic [1:0] s);
        logic [27:0] r;
        r = (s == 2'd2) ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] h, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] o;
        logic [31:0] r;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) x[47-i] = h[32-int'(PERM_E[i])];
        x = x ^ k;
        for (int b = 0; b < 8; b++)
        begin
            six = x[47-6*b -: 6];
            o[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) r[31-i] = o[32-int'(PERM_P[i])];
        return r;
    endfunction

endpackage

// ===== rtl/core/tdc_front.sv =====
module tdc_front #(
    parameter int BLOCK_BYTES = tdc_pkg::BLOCK_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tdc_pkg::in_item_t   in_item,
    input  logic                ctr_load,
    input  logic [63:0]         ctr_value,
    input  logic [6:0]          ctr_bits,
    input  tdc_pkg::q_status_t  q_status,
    output logic                q_push,
    output tdc_pkg::job_t       q_job
);
    import tdc_pkg::*;

    localparam int NB_W = $clog2(BLOCK_BYTES + 1);

    logic [63:0] ctr_reg;
    logic [63:0] ctr_next;
    logic [63:0] ctr_inc;
    logic [63:0] wmask;
    logic [63:0] keep;
    logic [6:0]  width;
    logic [3:0]  nb;

    assign full   = q_status.queue_full;
    assign q_push = push && !full;

    always_comb
    begin
        width = ctr_bits;
        if (width == 7'd0)
            width = 7'd1;
        if (width > 7'd64)
            width = 7'd64;
        wmask = (width == 7'd64) ? '1 : ~({64{1'b1}} << width[5:0]);
        ctr_inc = ctr_reg + 64'd1;
        ctr_next = (ctr_reg & ~wmask) | (ctr_inc & wmask);
        nb = in_item.valid_bytes;
        if (nb >= 4'(BLOCK_BYTES))
            keep = '1;
        else if (nb == 4'd0)
            keep = '0;
        else
            keep = ~({64{1'b1}} >> {nb[NB_W-2:0], 3'b000});
    end

    assign q_job.ctr      = ctr_reg;
    assign q_job.data     = in_item.data_block;
    assign q_job.keep     = keep;
    assign q_job.next_ctr = ctr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctr_reg <= '0;
        else if (ctr_load)
            ctr_reg <= ctr_value;
        else if (q_push)
            ctr_reg <= ctr_next;
    end

endmodule

// ===== rtl/core/tdc_queue.sv =====
module tdc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  tdc_pkg::job_t       wr_job,
    input  logic                rd,
    output tdc_pkg::job_t       rd_job,
    output tdc_pkg::q_status_t  status
);
    import tdc_pkg::*;

    job_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wp_reg;
    logic [QUEUE_PTR_W-1:0] rp_reg;
    logic [QUEUE_PTR_W:0]   cnt_reg;

    assign status.queue_full  = (cnt_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign status.queue_empty = (cnt_reg == '0);
    assign rd_job = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QUEUE_PTR_W+1)'(wr) - (QUEUE_PTR_W+1)'(rd);
        end
    end

endmodule

// ===== rtl/core/tdc_engine.sv =====
module tdc_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         key_one,
    input  logic [63:0]         key_two,
    input  logic [63:0]         key_three,
    input  tdc_pkg::q_status_t  q_status,
    input  tdc_pkg::job_t       q_job,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output tdc_pkg::out_item_t  out_item
);
    import tdc_pkg::*;

    `include "tdes_ede_ctr_mode_core_defines.svh"

    eng_state_t        st_reg, st_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [31:0]       l_reg, l_next, r_reg, r_next;
    logic [27:0]       c_reg, c_next, d_reg, d_next;
    logic [63:0]       data_reg, data_next, keep_reg, keep_next, nctr_reg, nctr_next;
    out_item_t         res_reg, res_next;
    logic              full_reg, full_next;

    logic [63:0] key_sel, blk_out, ip_in;
    logic [55:0] cd0;
    logic [27:0] c_use, d_use, c_nx, d_nx;
    logic [47:0] sub;
    logic [31:0] f;
    logic        dec;

    assign empty    = !full_reg;
    assign out_item = res_reg;

    always_comb
    begin
        key_sel = key_one;
        dec     = 1'b0;
        case (pass_reg)
            2'd0: key_sel = key_one;
            2'd1:
            begin
                key_sel = key_two;
                dec     = 1'b1;
            end
            2'd2: key_sel = key_three;
            default: key_sel = key_one;
        endcase
        // encrypt rotates before using the subkey, decrypt after
        if (dec)
        begin
            c_use = c_reg;
            d_use = d_reg;
            c_nx  = rotr28(c_reg, ROT_AMT[4'd15 - rnd_reg]);
            d_nx  = rotr28(d_reg, ROT_AMT[4'd15 - rnd_reg]);
        end
        else
        begin
            c_use = rotl28(c_reg, ROT_AMT[rnd_reg]);
            d_use = rotl28(d_reg, ROT_AMT[rnd_reg]);
            c_nx  = c_use;
            d_nx  = d_use;
        end
        sub     = pc2_f({c_use, d_use});
        f       = feistel(r_reg, sub);
        blk_out = perm_fp_f({l_reg ^ f, r_reg});
        cd0     = pc1_f(key_sel);
    end

    always_comb
    begin
        st_next   = st_reg;
        rnd_next  = rnd_reg;
        pass_next = pass_reg;
        l_next    = l_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        data_next = data_reg;
        keep_next = keep_reg;
        nctr_next = nctr_reg;
        res_next  = res_reg;
        full_next = full_reg;
        q_pop     = 1'b0;
        ip_in     = q_job.ctr;
        if (full_reg && pop)
            full_next = 1'b0;
        case (st_reg)
            ENG_IDLE:
            begin
                if (!q_status.queue_empty)
                begin
                    q_pop     = 1'b1;
                    ip_in     = q_job.ctr;
                    {l_next, r_next} = perm_ip_f(ip_in);
                    c_next    = cd0[55:28];
                    d_next    = cd0[27:0];
                    data_next = q_job.data;
                    keep_next = q_job.keep;
                    nctr_next = q_job.next_ctr;
                    rnd_next  = '0;
                    pass_next = '0;
                    st_next   = ENG_RUN;
                end
            end
            ENG_RUN:
            begin
                l_next   = r_reg;
                r_next   = l_reg ^ f;
                c_next   = c_nx;
                d_next   = d_nx;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == RND_W'(ROUNDS - 1))
                begin
                    if (pass_reg == PASS_W'(PASSES - 1))
                        st_next = ENG_DONE;
                    else
                    begin
                        pass_next = pass_reg + 1'b1;
                        ip_in     = blk_out;
                        {l_next, r_next} = perm_ip_f(ip_in);
                        // schedule for next pass loaded from its key below
                        if (pass_reg == 2'd0)
                            {c_next, d_next} = pc1_f(key_two);
                        else
                            {c_next, d_next} = pc1_f(key_three);
                    end
                end
            end
            ENG_DONE:
            begin
                if (!full_next)
                begin
                    res_next.result_block = (data_reg ^ perm_fp_f({r_reg, l_reg})) & keep_reg;
                    res_next.next_counter = nctr_reg;
                    full_next = 1'b1;
                    pass_next = '0;
                    st_next   = ENG_IDLE;
                end
            end
            default: st_next = ENG_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ENG_IDLE;
            full_reg <= 1'b0;
            rnd_reg  <= '0;
            pass_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            full_reg <= full_next;
            rnd_reg  <= rnd_next;
            pass_reg <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        data_reg <= data_next;
        keep_reg <= keep_next;
        nctr_reg <= nctr_next;
        res_reg  <= res_next;
    end

    `TDC_ASSERT_IMPL(a_pop_only_idle, clk, rst_n, q_pop, st_reg == ENG_IDLE)
    `TDC_ASSERT_NEXT(a_run_after_pop, clk, rst_n, q_pop, st_reg == ENG_RUN && rnd_reg == '0)
    `TDC_ASSERT_IMPL(a_pass_range, clk, rst_n, st_reg == ENG_RUN, pass_reg != 2'd3)

endmodule

// ===== rtl/core/tdes_ede_ctr_mode_core.sv =====
// channel   direction  handshake            payload
// input     in         push / full          in_item (data_block, valid_bytes)
// result    out        empty / pop          out_item (result_block, next_counter)
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
// Each request runs 48 DES rounds in the engine, one per cycle, after a load step,
// then a write-out step that waits for room; the shared round unit sets the rate.
// Front computes the counter and byte mask at accept; a 2-entry queue decouples it.
// Reset clears the counter to 0, keys to 0, counter_bits to 64.
// A held result stalls the engine at write-out; the front stops once the queue is full.
module tdes_ede_ctr_mode_core #(
    parameter int BLOCK_BYTES = tdc_pkg::BLOCK_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tdc_pkg::in_item_t   in_item,
    output logic                empty,
    input  logic                pop,
    output tdc_pkg::out_item_t  out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import tdc_pkg::*;

    logic [63:0] k1_reg, k2_reg, k3_reg;
    logic [6:0]  cbits_reg;
    logic        cfg_wr;
    logic        q_push, q_pop;
    job_t        q_in, q_out;
    q_status_t   q_status;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg    <= '0;
            k2_reg    <= '0;
            k3_reg    <= '0;
            cbits_reg <= 7'd64;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_KEY_ONE:   k1_reg    <= cfg_data;
                CFG_KEY_TWO:   k2_reg    <= cfg_data;
                CFG_KEY_THREE: k3_reg    <= cfg_data;
                CFG_INIT_CTR:  ;  // loaded straight into the front counter
                CFG_CTR_BITS:  cbits_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    tdc_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .ctr_load(cfg_wr && cfg_index == CFG_INIT_CTR), .ctr_value(cfg_data),
        .ctr_bits(cbits_reg), .q_status(q_status), .q_push(q_push), .q_job(q_in)
    );

    tdc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(q_push), .wr_job(q_in), .rd(q_pop),
        .rd_job(q_out), .status(q_status)
    );

    tdc_engine u_engine (
        .clk(clk), .rst_n(rst_n), .key_one(k1_reg), .key_two(k2_reg),
        .key_three(k3_reg), .q_status(q_status), .q_job(q_out), .q_pop(q_pop),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

endmodule

// ===== sim/tb_tdes_ede_ctr_mode_core.sv =====
module tb_tdes_ede_ctr_mode_core;
    import tdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    in_item;
    logic        empty;
    logic        pop;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_cycles;
    int          idle_cycles;
    int          error_count;
    int          requests_sent;
    int          results_seen;
    int          tail_requests;
    int          config_writes;
    bit          timed_out;

    tdes_ede_ctr_mode_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // TDES-EDE keystream and counter predictor
    class ctr_keystream_sb;
        logic [63:0] key_one;
        logic [63:0] key_two;
        logic [63:0] key_three;
        logic [63:0] counter;
        logic [6:0]  counter_bits;
        out_item_t   pending[$];

        function new();
            key_one = '0;
            key_two = '0;
            key_three = '0;
            counter = '0;
            counter_bits = 7'd64;
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [63:0] val);
            case (idx)
                CFG_KEY_ONE:   key_one = val;
                CFG_KEY_TWO:   key_two = val;
                CFG_KEY_THREE: key_three = val;
                CFG_INIT_CTR:  counter = val;
                CFG_CTR_BITS:  counter_bits = val[6:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] round_fn(input logic [31:0] h, input logic [47:0] k);
            logic [47:0] x;
            logic [31:0] o;
            logic [31:0] r;
            logic [5:0]  six;
            for (int i = 0; i < 48; i++) x[47-i] = h[32-int'(PERM_E[i])];
            x = x ^ k;
            for (int b = 0; b < 8; b++)
            begin
                six = x[47-6*b -: 6];
                o[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]} ];
            end
            for (int i = 0; i < 32; i++) r[31-i] = o[32-int'(PERM_P[i])];
            return r;
        endfunction

        function logic [63:0] des(input logic [63:0] blk, input logic [63:0] key,
                                  input bit decrypt);
            logic [47:0] sub [16];
            logic [55:0] cd;
            logic [55:0] cdr;
            logic [27:0] c;
            logic [27:0] d;
            logic [63:0] v;
            logic [63:0] w;
            logic [31:0] hi;
            logic [31:0] lo;
            logic [31:0] t;
            for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(PERM_PC1[i])];
            c = cd[55:28];
            d = cd[27:0];
            for (int i = 0; i < 16; i++)
            begin
                repeat (int'(ROT_AMT[i]))
                begin
                    c = {c[26:0], c[27]};
                    d = {d[26:0], d[27]};
                end
                cdr = {c, d};
                for (int j = 0; j < 48; j++) sub[i][47-j] = cdr[56-int'(PERM_PC2[j])];
            end
            for (int i = 0; i < 64; i++) v[63-i] = blk[64-int'(PERM_IP[i])];
            hi = v[63:32];
            lo = v[31:0];
            for (int i = 0; i < 16; i++)
            begin
                t = lo;
                lo = hi ^ round_fn(lo, sub[decrypt ? 15 - i : i]);
                hi = t;
            end
            v = {lo, hi};
            for (int i = 0; i < 64; i++) w[63-i] = v[64-int'(PERM_FP[i])];
            return w;
        endfunction

        function void note_request(input in_item_t req);
            logic [63:0] ks;
            logic [63:0] keep;
            logic [63:0] m;
            int          width;
            int          nb;
            out_item_t   exp;
            ks = des(counter, key_one, 0);
            ks = des(ks, key_two, 1);
            ks = des(ks, key_three, 0);
            nb = int'(req.valid_bytes);
            if (nb >= 8) keep = '1;
            else if (nb == 0) keep = '0;
            else keep = ~({64{1'b1}} >> (8 * nb));
            width = int'(counter_bits);
            if (width < 1) width = 1;
            if (width >= 64) counter = counter + 64'd1;
            else
            begin
                m = (64'd1 << width) - 64'd1;
                counter = (counter & ~m) | ((counter + 64'd1) & m);
            end
            exp.result_block = (req.data_block ^ ks) & keep;
            exp.next_counter = counter;
            pending.push_back(exp);
        endfunction

        task check_result(input out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", got.result_block, '0);
                return;
            end
            want = pending.pop_front();
            if (got.result_block !== want.result_block)
                report_mismatch("result_block", got.result_block, want.result_block);
            if (got.next_counter !== want.next_counter)
                report_mismatch("next_counter", got.next_counter, want.next_counter);
        endtask
    endclass

    ctr_keystream_sb sb;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                sb.note_request(in_item);
                requests_sent++;
            end
            if (pop && !empty)
            begin
                sb.check_result(out_item);
                results_seen++;
            end
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                timed_out = 1'b1;
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        config_writes++;
    endtask

    task automatic send_request(input logic [63:0] data, input logic [3:0] nb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        in_item <= '{data_block: data, valid_bytes: nb};
        do @(posedge clk); while (full);
    endtask

    task automatic end_burst();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (sb.pending.size() != 0 && n < WATCHDOG_LIMIT * 4)
        begin
            @(posedge clk);
            n++;
        end
        repeat (120) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [3:0] rand_nb();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 4'd8;
        if (r < 95) return 4'($urandom_range(7, 1));
        return 4'($urandom_range(15));
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_request(rand64(), rand_nb());
            if (rand_nb() == 4'd8 && $urandom_range(9) == 0)
            begin
                end_burst();
                drain();
                write_reg(3'($urandom_range(4)), rand64());
            end
        end
        end_burst();
        drain();
    endtask

    task automatic set_keys(input logic [63:0] k1, input logic [63:0] k2,
                            input logic [63:0] k3, input logic [63:0] ctr,
                            input logic [6:0] bits);
        write_reg(CFG_KEY_ONE, k1);
        write_reg(CFG_KEY_TWO, k2);
        write_reg(CFG_KEY_THREE, k3);
        write_reg(CFG_INIT_CTR, ctr);
        write_reg(CFG_CTR_BITS, {57'd0, bits});
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        idle_cycles = 0;
        error_count = 0;
        requests_sent = 0;
        results_seen = 0;
        tail_requests = 0;
        config_writes = 0;
        timed_out = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset config, then extremes
        send_request(64'h0, 4'd8);
        send_request('1, 4'd8);
        end_burst();
        drain();
        set_keys('1, '1, '1, '1, 7'd64);
        for (int nb = 0; nb < 16; nb++)
            send_request('1, 4'(nb));
        end_burst();
        drain();
        set_keys(64'h0123456789ABCDEF, 64'h23456789ABCDEF01, 64'h456789ABCDEF0123,
                 64'hFFFF_FFFF_FFFF_FFFE, 7'd1);
        send_request(64'h5555_AAAA_5555_AAAA, 4'd8);
        send_request(64'hAAAA_5555_AAAA_5555, 4'd3);
        send_request(64'h8000_0000_0000_0001, 4'd8);
        end_burst();
        drain();
        write_reg(CFG_CTR_BITS, 64'd0);
        send_request(64'h1, 4'd8);
        send_request(64'h2, 4'd8);
        end_burst();
        drain();
        write_reg(CFG_CTR_BITS, 64'd127);
        write_reg(3'd7, rand64());
        write_reg(3'd5, rand64());
        send_request(64'h3, 4'd8);
        end_burst();
        drain();

        // random phases with differing idle profiles
        set_keys(rand64(), rand64(), rand64(), rand64(), 7'($urandom_range(64, 1)));
        send_idle_pct = 0;  recv_stall_pct = 0;
        random_phase(150);
        set_keys(rand64(), rand64(), rand64(), {32'hFFFF_FFFF, $urandom}, 7'd8);
        send_idle_pct = 47; recv_stall_pct = 0;
        random_phase(150);
        set_keys(rand64(), rand64(), rand64(), rand64(), 7'd63);
        send_idle_pct = 0;  recv_stall_pct = 47;
        random_phase(150);
        set_keys(rand64(), rand64(), rand64(), rand64(), 7'($urandom_range(64, 1)));
        send_idle_pct = 15; recv_stall_pct = 15;
        random_phase(150);

        // fill the block while the receiver holds off
        send_idle_pct = 0;  recv_stall_pct = 0;
        hold_off_cycles = 600;
        random_phase(100);

        if (!timed_out)
        begin
            $display("covered %0d requests, %0d results, %0d config writes",
                     requests_sent, results_seen, config_writes);
            $display("idle profiles none/send/recv/both plus a long receiver hold-off");
            if (error_count == 0 && sb.pending.size() == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
            $finish;
        end
    end
endmodule
